>>> rtl/quaternion_rotate_vector_unit_macros.svh
// Assertion macros for the quaternion rotate vector unit.
// No dependencies; included by the top level.
`ifndef QUATERNION_ROTATE_VECTOR_UNIT_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR_UNIT_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define QRV_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression must never be true outside reset
`define QRV_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define QRV_ASSERT(label, clk, rst_n, prop)
`define QRV_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

>>> rtl/qrv_pkg.sv
// Shared widths, payload structs and pipeline bus types for the quaternion
// rotate vector unit. No dependencies.
`timescale 1ns / 1ps
package qrv_pkg;
    localparam int CompW  = 16;             // component width
    localparam int ProdW  = 2 * CompW;      // q*q products
    localparam int MatW   = 2 * CompW + 2;  // scaled matrix entries
    localparam int DenW   = 2 * CompW + 1;  // squared norm
    localparam int TermW  = 3 * CompW + 2;  // matrix entry times vector
    localparam int NumW   = 3 * CompW + 4;  // numerator sum
    localparam int QuotW  = CompW + 1;      // quotient magnitude bits
    localparam int Latency = QuotW + 5;     // start transfer to result strobe

    typedef logic signed [CompW-1:0] t_comp;
    typedef logic signed [MatW-1:0]  t_mat_elem;

    typedef struct packed {
        logic signed [CompW-1:0] quat_x;
        logic signed [CompW-1:0] quat_y;
        logic signed [CompW-1:0] quat_z;
        logic signed [CompW-1:0] quat_w;
        logic signed [CompW-1:0] vec_x;
        logic signed [CompW-1:0] vec_y;
        logic signed [CompW-1:0] vec_z;
    } t_item;

    typedef struct packed {
        logic signed [CompW-1:0] rot_x;
        logic signed [CompW-1:0] rot_y;
        logic signed [CompW-1:0] rot_z;
        logic                    saturated;
        logic                    zero_quaternion;
    } t_result;

    // control travelling alongside the divider datapath
    typedef struct packed {
        logic            valid;
        logic            zero;
        logic [2:0]      neg;
        logic [DenW-1:0] den;
    } t_num_bus;
endpackage

>>> rtl/qrv_matrix.sv
// Stages 1-2: quaternion products, then the rotation matrix scaled by |q|^2
// and the squared norm. Depends on qrv_pkg.
`timescale 1ns / 1ps
module qrv_matrix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  qrv_pkg::t_item        i_item,
    output logic                  o_valid,
    output qrv_pkg::t_mat_elem    o_mat [9],
    output qrv_pkg::t_comp        o_vec [3],
    output logic [qrv_pkg::DenW-1:0] o_den
);
    localparam int PW = qrv_pkg::ProdW;
    localparam int MW = qrv_pkg::MatW;
    localparam int DW = qrv_pkg::DenW;

    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_ww, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    qrv_pkg::t_comp       r_v1 [3];
    logic                 r_valid1;
    qrv_pkg::t_mat_elem   r_mat [9];
    qrv_pkg::t_comp       r_v2 [3];
    logic [DW-1:0]        r_den;
    logic                 r_valid2;

    // stage 1: ten pairwise products
    always_ff @(posedge i_clk) begin
        r_xx <= PW'(i_item.quat_x) * PW'(i_item.quat_x);
        r_yy <= PW'(i_item.quat_y) * PW'(i_item.quat_y);
        r_zz <= PW'(i_item.quat_z) * PW'(i_item.quat_z);
        r_ww <= PW'(i_item.quat_w) * PW'(i_item.quat_w);
        r_xy <= PW'(i_item.quat_x) * PW'(i_item.quat_y);
        r_xz <= PW'(i_item.quat_x) * PW'(i_item.quat_z);
        r_yz <= PW'(i_item.quat_y) * PW'(i_item.quat_z);
        r_wx <= PW'(i_item.quat_w) * PW'(i_item.quat_x);
        r_wy <= PW'(i_item.quat_w) * PW'(i_item.quat_y);
        r_wz <= PW'(i_item.quat_w) * PW'(i_item.quat_z);
        r_v1[0] <= i_item.vec_x;
        r_v1[1] <= i_item.vec_y;
        r_v1[2] <= i_item.vec_z;
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
        end
    end

    // stage 2: matrix entries, row major, and |q|^2
    always_ff @(posedge i_clk) begin
        r_mat[0] <= MW'(r_ww) + MW'(r_xx) - MW'(r_yy) - MW'(r_zz);
        r_mat[1] <= (MW'(r_xy) - MW'(r_wz)) <<< 1;
        r_mat[2] <= (MW'(r_xz) + MW'(r_wy)) <<< 1;
        r_mat[3] <= (MW'(r_xy) + MW'(r_wz)) <<< 1;
        r_mat[4] <= MW'(r_ww) - MW'(r_xx) + MW'(r_yy) - MW'(r_zz);
        r_mat[5] <= (MW'(r_yz) - MW'(r_wx)) <<< 1;
        r_mat[6] <= (MW'(r_xz) - MW'(r_wy)) <<< 1;
        r_mat[7] <= (MW'(r_yz) + MW'(r_wx)) <<< 1;
        r_mat[8] <= MW'(r_ww) - MW'(r_xx) - MW'(r_yy) + MW'(r_zz);
        r_den <= DW'($unsigned(r_xx)) + DW'($unsigned(r_yy))
               + DW'($unsigned(r_zz)) + DW'($unsigned(r_ww));
        r_v2 <= r_v1;
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
        end else begin
            r_valid2 <= r_valid1;
        end
    end

    assign o_valid = r_valid2;
    assign o_mat   = r_mat;
    assign o_vec   = r_v2;
    assign o_den   = r_den;
endmodule

>>> rtl/qrv_mac.sv
// Stages 3-4: matrix times vector, row sums, sign and magnitude split.
// Depends on qrv_pkg.
`timescale 1ns / 1ps
module qrv_mac (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  qrv_pkg::t_mat_elem       i_mat [9],
    input  qrv_pkg::t_comp           i_vec [3],
    input  logic [qrv_pkg::DenW-1:0] i_den,
    output qrv_pkg::t_num_bus        o_bus,
    output logic [qrv_pkg::NumW-1:0] o_mag [3]
);
    localparam int TW = qrv_pkg::TermW;
    localparam int NW = qrv_pkg::NumW;

    logic signed [TW-1:0]    r_term [9];
    logic [qrv_pkg::DenW-1:0] r_den3;
    logic                    r_valid3;
    logic [NW-1:0]           r_mag [3];
    qrv_pkg::t_num_bus       r_bus;
    logic signed [NW-1:0]    n_sum [3];

    // stage 3: nine products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 9; i++) begin
            r_term[i] <= TW'(i_mat[i]) * TW'(i_vec[i % 3]);
        end
        r_den3 <= i_den;
        if (!i_rst_n) begin
            r_valid3 <= 1'b0;
        end else begin
            r_valid3 <= i_valid;
        end
    end

    // row sums
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_sum[r] = NW'(r_term[3*r]) + NW'(r_term[3*r+1]) + NW'(r_term[3*r+2]);
        end
    end

    // stage 4: sign and magnitude
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 3; r++) begin
            r_mag[r]     <= n_sum[r][NW-1] ? $unsigned(-n_sum[r]) : $unsigned(n_sum[r]);
            r_bus.neg[r] <= n_sum[r][NW-1];
        end
        r_bus.den  <= r_den3;
        r_bus.zero <= (r_den3 == '0);
        if (!i_rst_n) begin
            r_bus.valid <= 1'b0;
        end else begin
            r_bus.valid <= r_valid3;
        end
    end

    assign o_bus = r_bus;
    assign o_mag = r_mag;
endmodule

>>> rtl/qrv_div.sv
// Restoring divider pipeline, one quotient bit per stage, then rounding
// half away from zero and saturation. Depends on qrv_pkg.
`timescale 1ns / 1ps
module qrv_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  qrv_pkg::t_num_bus        i_bus,
    input  logic [qrv_pkg::NumW-1:0] i_mag [3],
    output logic                     o_valid,
    output qrv_pkg::t_result         o_result
);
    localparam int NW = qrv_pkg::NumW;
    localparam int QW = qrv_pkg::QuotW;
    localparam int DW = qrv_pkg::DenW;
    localparam int CW = qrv_pkg::CompW;
    localparam logic [QW:0] PosLim = (QW+1)'((1 << (CW-1)) - 1);
    localparam logic [QW:0] NegLim = (QW+1)'(1 << (CW-1));

    qrv_pkg::t_num_bus r_bus [QW];
    logic [NW-1:0]     r_rem [QW][3];
    logic [QW-1:0]     r_q   [QW][3];
    logic              r_valid;
    qrv_pkg::t_result  r_result;

    // divider stages
    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int Bit = QW - 1 - s;
        qrv_pkg::t_num_bus bus_in;
        if (s == 0) begin : g_first
            assign bus_in = i_bus;
        end else begin : g_next
            assign bus_in = r_bus[s-1];
        end

        // control follows the data; only the valid bit is reset
        always_ff @(posedge i_clk) begin
            r_bus[s].zero <= bus_in.zero;
            r_bus[s].neg  <= bus_in.neg;
            r_bus[s].den  <= bus_in.den;
            if (!i_rst_n) begin
                r_bus[s].valid <= 1'b0;
            end else begin
                r_bus[s].valid <= bus_in.valid;
            end
        end

        for (genvar c = 0; c < 3; c++) begin : g_comp
            logic [NW-1:0] rem_in, dsh;
            logic [QW-1:0] q_in, n_q;
            logic          ge;
            if (s == 0) begin : g_first
                assign rem_in = i_mag[c];
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = r_rem[s-1][c];
                assign q_in   = r_q[s-1][c];
            end
            assign dsh = NW'(bus_in.den) << Bit;
            assign ge  = (rem_in >= dsh);
            always_comb begin
                n_q      = q_in;
                n_q[Bit] = ge;
            end
            always_ff @(posedge i_clk) begin
                r_rem[s][c] <= ge ? rem_in - dsh : rem_in;
                r_q[s][c]   <= n_q;
            end
        end
    end

    // round, saturate, zero-quaternion override
    logic [CW-1:0] n_rot [3];
    logic [2:0]    n_sat;
    always_comb begin
        logic [DW:0] twice;
        logic [QW:0] m;
        for (int c = 0; c < 3; c++) begin
            twice = {r_rem[QW-1][c][DW-1:0], 1'b0};
            m = (QW+1)'(r_q[QW-1][c]) + (QW+1)'(twice >= {1'b0, r_bus[QW-1].den});
            if (r_bus[QW-1].neg[c]) begin
                n_sat[c] = (m > NegLim);
                if (n_sat[c]) m = NegLim;
                n_rot[c] = CW'(-m);
            end else begin
                n_sat[c] = (m > PosLim);
                if (n_sat[c]) m = PosLim;
                n_rot[c] = CW'(m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_bus[QW-1].zero) begin
            r_result <= '{rot_x: '0, rot_y: '0, rot_z: '0,
                          saturated: 1'b0, zero_quaternion: 1'b1};
        end else begin
            r_result <= '{rot_x: n_rot[0], rot_y: n_rot[1], rot_z: n_rot[2],
                          saturated: |n_sat, zero_quaternion: 1'b0};
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_bus[QW-1].valid;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;
endmodule

>>> rtl/quaternion_rotate_vector_unit.sv
// Top level of the quaternion rotate vector unit.
// Depends on qrv_pkg, qrv_matrix, qrv_mac, qrv_div and the macros header.
`timescale 1ns / 1ps
// Usage:
//   Command channel: drive i_item and raise start; the transfer happens at a
//   rising edge where start is high and busy is low. busy is high during reset
//   and for the first cycle after reset is released, low at all other times.
//   Result channel: o_valid strobes for one cycle with o_result; there is no
//   back-pressure, the receiver must take it in that cycle.
//   Pipeline: four stages of products, matrix, vector multiply and sums,
//   then one stage per quotient bit (17) of the restoring divider, then one
//   rounding stage that registers o_result and the o_valid strobe.
//   Throughput: one item per cycle while busy is low, fully pipelined, results in input order.
//   The result is q*(0,v)*conj(q) divided by |q|^2, rounded half away from
//   zero and saturated to 16 bits; a zero quaternion returns zero with the
//   zero_quaternion flag set.
//   Reset (synchronous, active low) clears all valid bits; items in flight
//   are dropped.
module quaternion_rotate_vector_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  qrv_pkg::t_item    i_item,
    output logic              o_valid,
    output qrv_pkg::t_result  o_result
);
`include "quaternion_rotate_vector_unit_macros.svh"

    logic r_busy;
    logic accept;

    logic                     mat_valid;
    qrv_pkg::t_mat_elem       mat [9];
    qrv_pkg::t_comp           mat_vec [3];
    logic [qrv_pkg::DenW-1:0] mat_den;
    qrv_pkg::t_num_bus        num_bus;
    logic [qrv_pkg::NumW-1:0] num_mag [3];

    // busy for one cycle coming out of reset
    always_ff @(posedge i_clk) begin
        r_busy <= !i_rst_n;
    end
    assign busy   = r_busy;
    assign accept = start && !r_busy;

    qrv_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .o_valid (mat_valid),
        .o_mat   (mat),
        .o_vec   (mat_vec),
        .o_den   (mat_den)
    );

    qrv_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mat_valid),
        .i_mat   (mat),
        .i_vec   (mat_vec),
        .i_den   (mat_den),
        .o_bus   (num_bus),
        .o_mag   (num_mag)
    );

    qrv_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bus    (num_bus),
        .i_mag    (num_mag),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // checks
    `QRV_ASSERT(a_latency, i_clk, i_rst_n, accept |-> ##(qrv_pkg::Latency) o_valid)
    `QRV_ASSERT(a_zero_result, i_clk, i_rst_n, (o_valid && o_result.zero_quaternion) |-> (o_result.rot_x == '0 && o_result.rot_y == '0 && o_result.rot_z == '0 && !o_result.saturated))
    `QRV_ASSERT_NEVER(a_busy_idle, i_clk, i_rst_n, busy && o_valid)
endmodule

>>> dv/tb.sv
// Testbench for quaternion_rotate_vector_unit: drives quaternion/vector items,
// predicts each rotated, rounded and saturated result, checks in order.
// Depends on qrv_pkg and the RTL of the unit.
`timescale 1ns / 1ps

// Scoreboard: rotation predictor plus queue of expected results
class rotation_scoreboard;
    qrv_pkg::t_result pending_rot[$];
    int mismatches;
    int checked;
    int sat_seen;
    int zero_seen;

    // exact rational rotation, rounded half away from zero, saturated
    static function qrv_pkg::t_result rotate(qrv_pkg::t_item it);
        qrv_pkg::t_result r;
        logic signed [127:0] qx, qy, qz, qw, vx, vy, vz, den;
        logic signed [127:0] num [3];
        logic [127:0] mag, quo, rem;
        logic signed [127:0] val;
        bit sat;
        qx = it.quat_x; qy = it.quat_y; qz = it.quat_z; qw = it.quat_w;
        vx = it.vec_x; vy = it.vec_y; vz = it.vec_z;
        den = qx*qx + qy*qy + qz*qz + qw*qw;
        r = '0;
        if (den == 0) begin
            r.zero_quaternion = 1'b1;
            return r;
        end
        num[0] = (qw*qw + qx*qx - qy*qy - qz*qz)*vx + 2*(qx*qy - qw*qz)*vy
               + 2*(qx*qz + qw*qy)*vz;
        num[1] = 2*(qx*qy + qw*qz)*vx + (qw*qw - qx*qx + qy*qy - qz*qz)*vy
               + 2*(qy*qz - qw*qx)*vz;
        num[2] = 2*(qx*qz - qw*qy)*vx + 2*(qy*qz + qw*qx)*vy
               + (qw*qw - qx*qx - qy*qy + qz*qz)*vz;
        sat = 0;
        for (int i = 0; i < 3; i++) begin
            mag = num[i] < 0 ? -num[i] : num[i];
            quo = mag / den;
            rem = mag % den;
            if (2*rem >= den) quo++;
            if (num[i] < 0) begin
                if (quo > 32768) begin quo = 32768; sat = 1; end
                val = -$signed(quo);
            end else begin
                if (quo > 32767) begin quo = 32767; sat = 1; end
                val = quo;
            end
            case (i)
                0: r.rot_x = val[15:0];
                1: r.rot_y = val[15:0];
                default: r.rot_z = val[15:0];
            endcase
        end
        r.saturated = sat;
        return r;
    endfunction

    function void note_item(qrv_pkg::t_item it);
        qrv_pkg::t_result r;
        r = rotate(it);
        if (r.saturated) sat_seen++;
        if (r.zero_quaternion) zero_seen++;
        pending_rot.push_back(r);
    endfunction

    function void check_result(qrv_pkg::t_result got);
        qrv_pkg::t_result want;
        if (pending_rot.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        want = pending_rot.pop_front();
        checked++;
        if (got.rot_x !== want.rot_x || got.rot_y !== want.rot_y ||
            got.rot_z !== want.rot_z || got.saturated !== want.saturated ||
            got.zero_quaternion !== want.zero_quaternion) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp x=%0d y=%0d z=%0d s=%b z0=%b got x=%0d y=%0d z=%0d s=%b z0=%b",
                    want.rot_x, want.rot_y, want.rot_z, want.saturated,
                    want.zero_quaternion, got.rot_x, got.rot_y, got.rot_z,
                    got.saturated, got.zero_quaternion);
        end
    endfunction
endclass

module tb;
    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    qrv_pkg::t_item   i_item = '0;
    logic             o_valid;
    qrv_pkg::t_result o_result;

    rotation_scoreboard rot_sb = new();
    bit      idle_enable = 1'b1;

    quaternion_rotate_vector_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_result(o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // note transfers and check results at each edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) rot_sb.note_item(i_item);
        if (i_rst_n && o_valid) rot_sb.check_result(o_result);
    end

    // one item transfer, with an optional random idle burst before it
    task automatic send_item(input qrv_pkg::t_item it);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic qrv_pkg::t_item rand_item();
        qrv_pkg::t_item it;
        it.quat_x = rand_comp(); it.quat_y = rand_comp();
        it.quat_z = rand_comp(); it.quat_w = rand_comp();
        it.vec_x = rand_comp(); it.vec_y = rand_comp(); it.vec_z = rand_comp();
        // occasional identity quaternion or zero quaternion
        case ($urandom_range(0, 9))
            0: {it.quat_x, it.quat_y, it.quat_z, it.quat_w} = '0;
            1: begin
                it.quat_x = '0; it.quat_y = '0; it.quat_z = '0;
                it.quat_w = 16'sd16384;
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic wait_drained();
        start <= 1'b0;
        while (rot_sb.pending_rot.size() != 0) @(posedge i_clk);
        repeat (qrv_pkg::Latency + 4) @(posedge i_clk);
    endtask

    initial begin
        qrv_pkg::t_item it;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: identity, zero quaternion, full-scale and saturating cases
        it = '0; it.quat_w = 16'sd16384;
        it.vec_x = 16'sd1234; it.vec_y = -16'sd5; it.vec_z = 16'h8000;
        send_item(it);
        it.quat_w = '0; send_item(it);
        it = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        send_item(it);
        it = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
        send_item(it);
        it = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'h7fff, 16'h8000, 16'h8000};
        send_item(it);
        it = '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 16'h7fff, 16'h7fff, 16'sd0};
        send_item(it); // near-unit quaternion, 90 degree turn about x
        it = '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'h7fff, 16'h7fff, 16'h7fff};
        send_item(it); // tiny quaternion, turn about the diagonal
        it = '{16'sd0, 16'sd1, 16'sd0, 16'sd1, 16'sd3, 16'sd1, -16'sd3};
        send_item(it); // non-unit norm, quarter turn about y
        it = '{16'hffff, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'hffff};
        send_item(it);

        // hold off until every result is back
        wait_drained();

        for (int n = 0; n < 650; n++) begin
            if (n == 500) idle_enable = 1'b0;
            send_item(rand_item());
        end
        wait_drained();

        $display("checked %0d rotations, %0d saturating, %0d zero quaternions",
            rot_sb.checked, rot_sb.sat_seen, rot_sb.zero_seen);
        if (rot_sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", rot_sb.mismatches);
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200000;
        $display("tb: failure");
        $finish;
    end
endmodule

>>> quaternion_rotate_vector_unit.f
+incdir+rtl
rtl/qrv_pkg.sv
rtl/qrv_matrix.sv
rtl/qrv_mac.sv
rtl/qrv_div.sv
rtl/quaternion_rotate_vector_unit.sv
dv/tb.sv
